FILE: rtl/assert_macros.svh
// Assertion macros shared by the histogram RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

FILE: rtl/hms_pkg.sv
// Package for the histogram mean and sigma block: constants, state type
package hms_pkg;
    localparam int HMS_BINS       = 256;
    localparam int HMS_COUNT_BITS = 22;
    localparam int PIX_W          = 8;
    localparam int PC_W           = 22;
    localparam int OUT_W          = 16;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_RUN,
        ST_WALK,
        ST_DIVM,
        ST_MUL,
        ST_DIVV,
        ST_SQRT,
        ST_DONE
    } t_state;
endpackage

FILE: rtl/hms_divider.sv
// Restoring divider, one quotient bit per cycle
module hms_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_rem;
    logic [DEN_W:0]   n_sub;

    always_comb begin
        n_rem = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_sub = n_rem - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                // shift in next dividend bit, subtract when it fits
                if (!n_sub[DEN_W]) begin
                    r_rem <= n_sub;
                    r_q   <= {r_q[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: rtl/histogram_mean_sigma.sv
// Top level: pixel histogram in block RAM, per-frame mean and sigma
//   channel | ports                                   | handshake
//   pixel   | i_pixel, i_last_pixel                   | i_start & !o_busy
//   result  | o_pixel_count, o_mean_level, o_std_dev  | o_valid, one cycle
// One pixel a cycle while running; writes from the two pixels before a read
// are forwarded. Reset runs a clear sweep over every bin with busy high.
// After the last pixel busy stays high through a walk that reads and clears
// the bins, three divides, a two-pass shift-add product and a bit-serial root.
// The result strobe cannot be stalled.
module histogram_mean_sigma #(
    parameter int BINS       = hms_pkg::HMS_BINS,
    parameter int COUNT_BITS = hms_pkg::HMS_COUNT_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [hms_pkg::PIX_W-1:0] i_pixel,
    input  logic                    i_last_pixel,
    output logic                    o_valid,
    output logic [hms_pkg::PC_W-1:0]  o_pixel_count,
    output logic [hms_pkg::OUT_W-1:0] o_mean_level,
    output logic [hms_pkg::OUT_W-1:0] o_std_dev
);
    import hms_pkg::*;
    `include "assert_macros.svh"

    localparam int AW   = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CB   = COUNT_BITS;
    localparam int S1W  = CB + AW + 8;
    localparam int S2W  = CB + 2*AW + 8;
    localparam int PW   = S1W + S2W + 1;      // product width for N*S2, S1*S1
    localparam int NUMW = PW + 16;
    localparam int DW   = CB + 9;
    localparam int MCW  = $clog2(S2W + 1);
    localparam logic [CB-1:0] CMAX = '1;

    t_state r_state, n_state;

    logic [CB-1:0] r_mem [BINS];
    logic [CB-1:0] r_rd;
    logic [AW-1:0] r_waddr, w_raddr;
    logic [CB-1:0] r_wdata;
    logic          r_we;
    logic [AW:0]   r_idx;

    // pixel pipe: stage 1 holds the bin whose read is in flight
    logic          r_p1v, r_p1last;
    logic [AW-1:0] r_p1bin;
    logic [CB-1:0] r_frame;

    logic [AW-1:0] w_bin;
    logic          w_acc;
    logic [CB-1:0] w_old, w_inc;

    // walk pipe
    logic          r_wv;
    logic [AW-1:0] r_wbin;
    logic [S1W+2:0]  r_n;   // N fits CB+AW
    logic [S1W-1:0]  r_s1;
    logic [S2W-1:0]  r_s2;
    logic [CB-1:0]   r_c;
    logic [AW-1:0]   r_ci;
    logic            r_cv;
    logic [CB+AW-1:0] r_ci1;
    logic [AW-1:0]    r_ci2;
    logic             r_cv2;

    logic [PW-1:0]   r_var;
    logic [PW-1:0]   r_md;
    logic [S2W-1:0]  r_mq;
    logic [MCW-1:0]  r_mcnt;
    logic            r_msub;
    logic [1:0]      r_phase;
    logic            r_dstart;
    logic [NUMW-1:0] r_dnum;
    logic [DW-1:0]   r_dden;
    logic            w_ddone;
    logic [NUMW-1:0] w_dq;

    logic [OUT_W-1:0] r_mean;
    logic [31:0]      r_sq_v, r_sq_res, r_sq_bit;
    logic             r_sat;
    logic [5:0]       r_sq_cnt;
    logic [PC_W-1:0]  r_pc;
    logic             r_valid;
    logic [OUT_W-1:0] r_sd;

    always_comb begin
        if (i_pixel > PIX_W'(BINS - 1)) w_bin = AW'(BINS - 1);
        else w_bin = AW'(i_pixel);
    end

    assign w_acc = i_start && !o_busy;

    // forward the bin just written when the next pixel reads the same entry
    always_comb begin
        w_old = (r_we && r_waddr == r_p1bin) ? r_wdata : r_rd;
        w_inc = (w_old == CMAX) ? w_old : w_old + 1'b1;
    end

    // a write landing on the entry being read hands its data straight over
    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_waddr] <= r_wdata;
        r_rd <= (r_we && r_waddr == w_raddr) ? r_wdata : r_mem[w_raddr];
    end

    always_comb begin
        w_raddr = (r_state == ST_WALK) ? r_idx[AW-1:0] : w_bin;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_idx == (AW+1)'(BINS - 1)) n_state = ST_RUN;
            ST_RUN:   if (r_p1v && r_p1last) n_state = ST_WALK;
            ST_WALK:  if (!r_wv && !r_cv && !r_cv2 && r_idx == (AW+1)'(BINS) && r_phase == 2'd3)
                          n_state = ST_DIVM;
            ST_DIVM:  if (w_ddone) n_state = ST_MUL;
            ST_MUL:   if (r_mcnt == '0 && r_msub) n_state = ST_DIVV;
            ST_DIVV:  if (w_ddone && r_phase == 2'd1) n_state = ST_SQRT;
            ST_SQRT:  if (r_sq_cnt == 6'd0) n_state = ST_DONE;
            ST_DONE:  n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_busy = (r_state != ST_RUN) || (r_p1v && r_p1last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_we    <= 1'b0;
            r_p1v   <= 1'b0;
            r_wv    <= 1'b0;
            r_cv    <= 1'b0;
            r_cv2   <= 1'b0;
            r_frame <= '0;
            r_valid <= 1'b0;
            r_dstart <= 1'b0;
            r_phase <= '0;
        end else begin
            r_state  <= n_state;
            r_we     <= 1'b0;
            r_valid  <= 1'b0;
            r_dstart <= 1'b0;
            r_p1v    <= w_acc;
            r_p1bin  <= w_bin;
            r_p1last <= i_last_pixel;
            r_wv     <= 1'b0;
            r_cv     <= r_wv;
            r_cv2    <= r_cv;
            unique case (r_state)
                ST_CLEAR: begin
                    r_we    <= 1'b1;
                    r_waddr <= r_idx[AW-1:0];
                    r_wdata <= '0;
                    r_idx   <= (r_idx == (AW+1)'(BINS - 1)) ? '0 : r_idx + 1'b1;
                end
                ST_RUN: begin
                    if (w_acc && r_frame != CMAX) r_frame <= r_frame + 1'b1;
                    if (r_p1v) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_p1bin;
                        r_wdata <= w_inc;
                    end
                    r_idx <= '0;
                    r_n <= '0; r_s1 <= '0; r_s2 <= '0;
                    r_phase <= '0;
                end
                ST_WALK: begin
                    // read bin, clear it, then accumulate through the r_c and r_ci1 stages
                    if (r_idx != (AW+1)'(BINS)) begin
                        if (r_phase == 2'd0) r_phase <= 2'd1;
                        else begin
                            r_wv   <= 1'b1;
                            r_wbin <= r_idx[AW-1:0];
                            r_we    <= 1'b1;
                            r_waddr <= r_idx[AW-1:0];
                            r_wdata <= '0;
                            r_idx  <= r_idx + 1'b1;
                        end
                    end else r_phase <= 2'd3;
                end
                ST_DIVM: ;
                ST_MUL: ;
                ST_DIVV: ;
                ST_SQRT: ;
                ST_DONE: begin
                    r_valid <= 1'b1;
                    r_frame <= '0;
                end
                default: ;
            endcase

            if (r_wv) begin
                r_c  <= r_rd;
                r_ci <= r_wbin;
            end
            if (r_cv) begin
                r_ci1 <= (CB+AW)'(r_c) * (CB+AW)'(r_ci);
                r_ci2 <= r_ci;
                r_n   <= r_n + ($bits(r_n))'(r_c);
            end
            if (r_cv2) begin
                r_s1 <= r_s1 + S1W'(r_ci1);
                r_s2 <= r_s2 + S2W'(r_ci1) * S2W'(r_ci2);
            end

            if (r_state == ST_WALK && n_state == ST_DIVM) begin
                r_dstart <= 1'b1;
                r_dnum   <= NUMW'({r_s1, 8'd0});
                r_dden   <= DW'(r_n);
                r_pc     <= (r_frame > CB'((1 << PC_W) - 1) && CB > PC_W) ?
                            '1 : PC_W'(r_frame);
            end
            if (r_state == ST_DIVM && w_ddone) begin
                r_mean <= (w_dq > NUMW'(16'hFFFF)) ? 16'hFFFF : w_dq[OUT_W-1:0];
                // first pass of the product: N times S2
                r_var  <= '0;
                r_md   <= PW'(r_n);
                r_mq   <= r_s2;
                r_mcnt <= MCW'(S2W);
                r_msub <= 1'b0;
            end
            // shift-add product, one multiplier bit a cycle
            if (r_state == ST_MUL) begin
                if (r_mcnt != '0) begin
                    if (r_mq[0]) r_var <= r_msub ? r_var - r_md : r_var + r_md;
                    r_md   <= r_md << 1;
                    r_mq   <= r_mq >> 1;
                    r_mcnt <= r_mcnt - 1'b1;
                end else if (!r_msub) begin
                    // second pass: subtract S1 squared
                    r_msub <= 1'b1;
                    r_md   <= PW'(r_s1);
                    r_mq   <= S2W'(r_s1);
                    r_mcnt <= MCW'(S2W);
                end
            end
            if (r_state == ST_DIVV && r_phase != 2'd2 && !r_dstart && r_phase != 2'd1) begin
                r_dstart <= 1'b1;
                r_dnum   <= {r_var, 16'd0};
                r_phase  <= 2'd2;
            end
            if (r_state == ST_DIVV && w_ddone && r_phase == 2'd2) begin
                r_dstart <= 1'b1;
                r_dnum   <= w_dq;
                r_phase  <= 2'd1;
            end
            if (r_state == ST_DIVV && w_ddone && r_phase == 2'd1) begin
                r_sat    <= (w_dq >> 32) != '0;
                r_sq_v   <= w_dq[31:0];
                r_sq_res <= '0;
                r_sq_bit <= 32'h4000_0000;
                r_sq_cnt <= 6'd16;
            end
            if (r_state == ST_SQRT && r_sq_cnt != 6'd0) begin
                if (r_sq_v >= r_sq_res + r_sq_bit) begin
                    r_sq_v   <= r_sq_v - (r_sq_res + r_sq_bit);
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_sq_cnt <= r_sq_cnt - 1'b1;
            end
            if (r_state == ST_SQRT && r_sq_cnt == 6'd0)
                r_sd <= r_sat ? 16'hFFFF : r_sq_res[OUT_W-1:0];
        end
    end

    hms_divider #(.NUM_W(NUMW), .DEN_W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (w_ddone),
        .o_quot  (w_dq)
    );

    assign o_valid       = r_valid;
    assign o_pixel_count = r_pc;
    assign o_mean_level  = r_mean;
    assign o_std_dev     = r_sd;

    `CHK_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_RUN, o_busy)
    `CHK_NEXT(a_valid_after_done, i_clk, i_rst_n, r_state == ST_DONE, o_valid)
    `CHK_IMPL(a_no_write_in_math, i_clk, i_rst_n, r_state == ST_SQRT, !r_we)
endmodule

FILE: tb/tb_histogram_mean_sigma.sv
// Testbench for the gray-level histogram with per-frame mean and sigma
`timescale 1ns / 100ps

module tb_histogram_mean_sigma;
    import hms_pkg::*;

    localparam int NBINS   = HMS_BINS;
    localparam int CBITS   = HMS_COUNT_BITS;
    localparam int DRAIN_CYCLES = 2000;

    typedef struct {
        logic [PC_W-1:0]  count;
        logic [OUT_W-1:0] mean;
        logic [OUT_W-1:0] sigma;
    } t_stats;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [PIX_W-1:0]   i_pixel;
    logic               i_last_pixel;
    logic               o_valid;
    logic [PC_W-1:0]    o_pixel_count;
    logic [OUT_W-1:0]   o_mean_level;
    logic [OUT_W-1:0]   o_std_dev;

    // predictor state
    longint unsigned hist [NBINS];
    longint unsigned frame_total;
    t_stats          stats_q[$];
    int              n_errors;
    int              idle_pct;

    histogram_mean_sigma dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_pixel       (i_pixel),
        .i_last_pixel  (i_last_pixel),
        .o_valid       (o_valid),
        .o_pixel_count (o_pixel_count),
        .o_mean_level  (o_mean_level),
        .o_std_dev     (o_std_dev)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // count one pixel; on the last one, work out the frame statistics
    task automatic count_pixel(input logic [PIX_W-1:0] px, input logic last);
        longint unsigned cmax;
        longint unsigned n, s1, s2, c, mn, sd;
        logic [191:0] var_num;
        logic [191:0] q;
        int idx;
        t_stats st;
        cmax = (64'd1 << CBITS) - 1;
        idx = (px > NBINS - 1) ? NBINS - 1 : px;
        if (hist[idx] < cmax) hist[idx]++;
        if (frame_total < cmax) frame_total++;
        if (!last) return;
        n = 0; s1 = 0; s2 = 0; mn = 0; sd = 0;
        for (int i = 0; i < NBINS; i++) begin
            c = hist[i];
            n += c;
            s1 += c * i;
            s2 += c * i * i;
        end
        if (n != 0) begin
            mn = (s1 << 8) / n;
            var_num = (192'(n) * 192'(s2) - 192'(s1) * 192'(s1)) << 16;
            q = var_num / 192'(n) / 192'(n);
            sd = (q[191:64] != 0) ? 64'hFFFF : int_sqrt(q[63:0]);
            if (sd > 64'hFFFF) sd = 64'hFFFF;
            if (mn > 64'hFFFF) mn = 64'hFFFF;
        end
        st.count = (frame_total > (64'd1 << PC_W) - 1) ? {PC_W{1'b1}} : frame_total[PC_W-1:0];
        st.mean  = mn[OUT_W-1:0];
        st.sigma = sd[OUT_W-1:0];
        stats_q.insert(stats_q.size(), st);
        for (int i = 0; i < NBINS; i++) hist[i] = 0;
        frame_total = 0;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        n_errors++;
    endtask

    // hand one word to the block, with an optional idle gap first;
    // start stays high on return and the next word or the caller drops it
    task automatic send_word(input logic [PIX_W-1:0] px, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start      <= 1'b1;
        i_pixel      <= px;
        i_last_pixel <= last;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        count_pixel(px, last);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int len, input int lo, input int hi);
        for (int k = 0; k < len; k++)
            send_word(8'($urandom_range(hi, lo)), k == len - 1);
    endtask

    task automatic test_directed();
        send_word(8'd0, 1'b1);
        send_word(8'd255, 1'b1);
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b1);
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'h55, 1'b1);
        for (int k = 0; k < 6; k++) send_word(8'd128, k == 5);
        send_word(8'd1, 1'b0);
        send_word(8'd2, 1'b0);
        send_word(8'd254, 1'b1);
    endtask

    task automatic test_random_frames();
        int sent;
        sent = 0;
        while (sent < 550) begin
            int len, lo, hi;
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
            lo = $urandom_range(255);
            hi = ($urandom_range(3) == 0) ? lo : $urandom_range(255, lo);
            if ($urandom_range(4) == 0) begin
                lo = 0;
                hi = 255;
            end
            idle_pct = (sent > 200 && sent < 320) ? 0 : 30;
            send_frame(len, lo, hi);
            sent += len;
        end
    endtask

    // compare each strobed result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (stats_q.size() == 0) begin
                report_mismatch("result with no frame pending");
            end else begin
                t_stats e;
                e = stats_q.pop_front();
                if (o_pixel_count !== e.count)
                    report_mismatch($sformatf("pixel_count %0d exp %0d", o_pixel_count, e.count));
                if (o_mean_level !== e.mean)
                    report_mismatch($sformatf("mean_level %h exp %h", o_mean_level, e.mean));
                if (o_std_dev !== e.sigma)
                    report_mismatch($sformatf("std_dev %h exp %h", o_std_dev, e.sigma));
            end
        end
    end

    initial begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int guard;
        n_errors     = 0;
        idle_pct     = 30;
        frame_total  = 0;
        for (int i = 0; i < NBINS; i++) hist[i] = 0;
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_pixel      = '0;
        i_last_pixel = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_frames();
        i_start <= 1'b0;
        guard = 0;
        while (stats_q.size() != 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0 && stats_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
